// ===== hdl/nidc_pkg.sv =====
// ----------------------------------------------------------------------------
// nidc_pkg
// Types, status codes and weight tables shared by the identity check blocks.
// ----------------------------------------------------------------------------
package nidc_pkg;

    localparam int unsigned NumDigits = 10;

    // Result status codes
    localparam logic [3:0] ST_NAT_OK     = 4'd0;
    localparam logic [3:0] ST_BAD_LEN    = 4'd1;
    localparam logic [3:0] ST_BAD_REGION = 4'd2;
    localparam logic [3:0] ST_BAD_TYPE   = 4'd3;
    localparam logic [3:0] ST_PUB_OK     = 4'd4;
    localparam logic [3:0] ST_PUB_BAD    = 4'd5;
    localparam logic [3:0] ST_PRI_OK     = 4'd6;
    localparam logic [3:0] ST_PRI_BAD    = 4'd7;
    localparam logic [3:0] ST_NAT_BAD    = 4'd8;

    localparam logic [3:0] ID_LENGTH    = 4'd10;
    localparam logic [6:0] REGION_RESET = 7'd24;

    // Register byte addresses
    localparam logic [2:0] ADDR_REGION_LIMIT = 3'd0;

    // Per-digit weights; a zero weight leaves the digit out of that sum.
    localparam logic [1:0] NAT_W [NumDigits] =
        '{2'd2, 2'd1, 2'd2, 2'd1, 2'd2, 2'd1, 2'd2, 2'd1, 2'd2, 2'd0};
    localparam logic [2:0] PUB_W [NumDigits] =
        '{3'd3, 3'd2, 3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd0, 3'd0};
    localparam logic [2:0] PRI_W [NumDigits] =
        '{3'd4, 3'd3, 3'd2, 3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd0};

    typedef enum logic [1:0] {
        KIND_NAT,
        KIND_PUB,
        KIND_PRI
    } kind_t;

    // Weighted contributions of one digit to each of the three sums
    typedef struct packed {
        logic [4:0] nat;
        logic [6:0] pub;
        logic [6:0] pri;
    } lane_prod_t;

    // Control word travelling alongside the lane products
    typedef struct packed {
        logic       valid;
        logic       pre_fail;
        logic [3:0] pre_status;
        kind_t      kind;
        logic [3:0] chk8;
        logic [3:0] chk9;
    } ctrl_t;

endpackage

// ===== hdl/nidc_lane.sv =====
// ----------------------------------------------------------------------------
// nidc_lane
// One digit lane: forms the digit's weighted terms for all three schemes.
// ----------------------------------------------------------------------------
module nidc_lane
    import nidc_pkg::*;
(
    input  logic       clk,
    input  logic [3:0] digit,
    input  logic [1:0] nat_w,
    input  logic [2:0] pub_w,
    input  logic [2:0] pri_w,
    output lane_prod_t prod
);

    lane_prod_t prod_reg;
    lane_prod_t prod_next;
    logic [4:0] nat_raw;

    always_comb
    begin
        nat_raw = 5'(digit) * 5'(nat_w);
        // Terms of ten or more lose nine, the digit sum of a doubled 0-9 digit.
        prod_next.nat = (nat_raw >= 5'd10) ? nat_raw - 5'd9 : nat_raw;
        prod_next.pub = 7'(digit) * 7'(pub_w);
        prod_next.pri = 7'(digit) * 7'(pri_w);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// ===== hdl/nidc_merge.sv =====
// ----------------------------------------------------------------------------
// nidc_merge
// Adds the lane terms, reduces them to check digits and forms the status.
// ----------------------------------------------------------------------------
module nidc_merge
    import nidc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  lane_prod_t prod [NumDigits],
    input  ctrl_t      ctrl_in,
    output logic       done,
    output logic [3:0] status
);

    logic [7:0] nat_sum_reg, nat_sum_next;
    logic [9:0] pub_sum_reg, pub_sum_next;
    logic [9:0] pri_sum_reg, pri_sum_next;
    ctrl_t      ctrl_reg;
    logic       done_reg;
    logic [3:0] status_reg, status_next;

    logic [3:0] nat_rem, pub_rem, pri_rem;
    logic [3:0] nat_chk, pub_chk, pri_chk;

    // Remainder by ten for sums below 256: reciprocal estimate, one correction.
    function automatic logic [3:0] mod10(input logic [7:0] x);
        logic [13:0] p;
        logic [7:0]  r;
        p = 14'(x) * 14'd51;
        r = x - 8'(p[13:9]) * 8'd10;
        if (r >= 8'd10)
        begin
            r = r - 8'd10;
        end
        return r[3:0];
    endfunction

    // Remainder by eleven for sums below 1024, same scheme.
    function automatic logic [3:0] mod11(input logic [9:0] x);
        logic [16:0] p;
        logic [9:0]  r;
        p = 17'(x) * 17'd93;
        r = x - 10'(p[16:10]) * 10'd11;
        if (r >= 10'd11)
        begin
            r = r - 10'd11;
        end
        return r[3:0];
    endfunction

    always_comb
    begin
        nat_sum_next = '0;
        pub_sum_next = '0;
        pri_sum_next = '0;
        for (int i = 0; i < NumDigits; i++)
        begin
            nat_sum_next = nat_sum_next + 8'(prod[i].nat);
            pub_sum_next = pub_sum_next + 10'(prod[i].pub);
            pri_sum_next = pri_sum_next + 10'(prod[i].pri);
        end
    end

    always_comb
    begin
        nat_rem = mod10(nat_sum_reg);
        pub_rem = mod11(pub_sum_reg);
        pri_rem = mod11(pri_sum_reg);
        nat_chk = (nat_rem == 4'd0) ? 4'd0 : 4'd10 - nat_rem;
        pub_chk = (pub_rem == 4'd0) ? 4'd0 : 4'd11 - pub_rem;
        pri_chk = (pri_rem == 4'd0) ? 4'd0 : 4'd11 - pri_rem;

        if (ctrl_reg.pre_fail)
        begin
            status_next = ctrl_reg.pre_status;
        end
        else
        begin
            case (ctrl_reg.kind)
                KIND_NAT: status_next = (nat_chk == ctrl_reg.chk9) ? ST_NAT_OK : ST_NAT_BAD;
                KIND_PUB: status_next = (pub_chk == ctrl_reg.chk8) ? ST_PUB_OK : ST_PUB_BAD;
                KIND_PRI: status_next = (pri_chk == ctrl_reg.chk9) ? ST_PRI_OK : ST_PRI_BAD;
                default:  status_next = ST_BAD_TYPE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ctrl_reg <= ctrl_in;
            done_reg <= ctrl_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        nat_sum_reg <= nat_sum_next;
        pub_sum_reg <= pub_sum_next;
        pri_sum_reg <= pri_sum_next;
        status_reg  <= status_next;
    end

    assign done   = done_reg;
    assign status = status_reg;

endmodule

// ===== hdl/national_id_check_digit.sv =====
// ----------------------------------------------------------------------------
// national_id_check_digit
// Ten-digit identity number check with mod-10 and mod-11 check digits.
// ----------------------------------------------------------------------------
// Registers: control and lane terms, then merge sums, then done and status.
// Throughput: one word per cycle; busy stays low, as the lanes and the merge
// pipeline take a new number every cycle with no stall.
// Reset: clears the pipeline valid bits and sets region_limit to 24.
// The receiver cannot stall; each status is shown for one cycle only.
module national_id_check_digit
    import nidc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  length,
    input  logic [3:0]  digit_0,
    input  logic [3:0]  digit_1,
    input  logic [3:0]  digit_2,
    input  logic [3:0]  digit_3,
    input  logic [3:0]  digit_4,
    input  logic [3:0]  digit_5,
    input  logic [3:0]  digit_6,
    input  logic [3:0]  digit_7,
    input  logic [3:0]  digit_8,
    input  logic [3:0]  digit_9,
    output logic        done,
    output logic [3:0]  status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [6:0] region_limit_reg;
    ctrl_t      ctrl_reg, ctrl_next;
    logic [3:0] digits [NumDigits];
    lane_prod_t prod [NumDigits];
    logic [7:0] region;

    assign digits = '{digit_0, digit_1, digit_2, digit_3, digit_4,
                      digit_5, digit_6, digit_7, digit_8, digit_9};

    // Configuration port
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_REGION_LIMIT) ? {25'd0, region_limit_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_limit_reg <= REGION_RESET;
        end
        else if (psel && penable && pwrite && (paddr == ADDR_REGION_LIMIT))
        begin
            region_limit_reg <= pwdata[6:0];
        end
    end

    assign busy = 1'b0;

    // Screening checks run alongside the lanes and ride with their results.
    always_comb
    begin
        region               = {1'b0, digit_0, 3'b000} + {3'b000, digit_0, 1'b0}
                               + {4'b0000, digit_1};
        ctrl_next.valid      = start;
        ctrl_next.chk8       = digit_8;
        ctrl_next.chk9       = digit_9;
        ctrl_next.pre_fail   = 1'b1;
        ctrl_next.pre_status = ST_BAD_TYPE;
        ctrl_next.kind       = KIND_NAT;

        if (digit_2 == 4'd6)
        begin
            ctrl_next.kind = KIND_PUB;
        end
        else if (digit_2 == 4'd9)
        begin
            ctrl_next.kind = KIND_PRI;
        end

        if (length != ID_LENGTH)
        begin
            ctrl_next.pre_status = ST_BAD_LEN;
        end
        else if (region == 8'd0 || region > {1'b0, region_limit_reg})
        begin
            ctrl_next.pre_status = ST_BAD_REGION;
        end
        else if (digit_2 == 4'd7 || digit_2 == 4'd8 || digit_2 > 4'd9)
        begin
            ctrl_next.pre_status = ST_BAD_TYPE;
        end
        else
        begin
            ctrl_next.pre_fail = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    for (genvar i = 0; i < NumDigits; i++)
    begin : g_lane
        nidc_lane u_lane
        (
            .clk   (clk),
            .digit (digits[i]),
            .nat_w (NAT_W[i]),
            .pub_w (PUB_W[i]),
            .pri_w (PRI_W[i]),
            .prod  (prod[i])
        );
    end

    nidc_merge u_merge
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .prod    (prod),
        .ctrl_in (ctrl_reg),
        .done    (done),
        .status  (status)
    );

endmodule

// ===== tb/national_id_check_digit_tb.sv =====
// ============================================================================
// national_id_check_digit_tb
// Self-checking bench for the ten-digit identity number check. Every number
// taken on start is scored against an independent model of the length, region,
// type and check-digit rules, and each done strobe is compared with the oldest
// predicted status word. The region limit is stepped through its extremes
// between phases, and the sender idles at several rates.
// ============================================================================
import nidc_pkg::*;

typedef struct packed {
    logic [3:0]      length;
    logic [9:0][3:0] digits;
} id_number_t;

typedef struct packed {
    id_number_t number;
    logic [3:0] status;
} status_due_t;

class id_status_board;
    logic [6:0]  region_limit;
    status_due_t due[$];
    int unsigned mismatches;

    function new();
        region_limit = REGION_RESET;
        mismatches   = 0;
    endfunction

    // Mod-10 doubling for natural persons, mod-11 weights for the others.
    function int unsigned check_digit_of(id_number_t n, kind_t kind);
        int unsigned pub_w [9];
        int unsigned pri_w [9];
        int unsigned sum;
        int unsigned term;
        int unsigned modulus;
        pub_w   = '{3, 2, 7, 6, 5, 4, 3, 2, 0};
        pri_w   = '{4, 3, 2, 7, 6, 5, 4, 3, 2};
        sum     = 0;
        modulus = (kind == KIND_NAT) ? 10 : 11;
        for (int i = 0; i < 9; i++)
        begin
            case (kind)
                KIND_NAT:
                begin
                    term = n.digits[i] * ((i % 2 == 0) ? 2 : 1);
                    if (term >= 10)
                        term -= 9;
                end
                KIND_PUB: term = n.digits[i] * pub_w[i];
                default:  term = n.digits[i] * pri_w[i];
            endcase
            sum += term;
        end
        return (sum % modulus == 0) ? 0 : modulus - sum % modulus;
    endfunction

    function logic [3:0] expected_status(id_number_t n);
        int unsigned region;
        int unsigned kind_digit;
        region     = 10 * n.digits[0] + n.digits[1];
        kind_digit = n.digits[2];
        if (n.length != ID_LENGTH)
            return ST_BAD_LEN;
        if (region == 0 || region > region_limit)
            return ST_BAD_REGION;
        if (kind_digit == 7 || kind_digit == 8 || kind_digit > 9)
            return ST_BAD_TYPE;
        if (kind_digit < 6)
            return (check_digit_of(n, KIND_NAT) == n.digits[9]) ? ST_NAT_OK : ST_NAT_BAD;
        if (kind_digit == 6)
            return (check_digit_of(n, KIND_PUB) == n.digits[8]) ? ST_PUB_OK : ST_PUB_BAD;
        return (check_digit_of(n, KIND_PRI) == n.digits[9]) ? ST_PRI_OK : ST_PRI_BAD;
    endfunction

    task report(string msg);
        mismatches++;
        $display("ERROR: %s", msg);
    endtask

    task note_number(id_number_t n);
        status_due_t entry;
        entry.number = n;
        entry.status = expected_status(n);
        due.push_back(entry);
    endtask

    task check_status(logic [3:0] got);
        status_due_t entry;
        if (due.size() == 0)
        begin
            report($sformatf("status %0d strobed with no number outstanding", got));
            return;
        end
        entry = due.pop_front();
        if (got !== entry.status)
            report($sformatf("length %0d digits(9..0) %h: status %0d, expected %0d",
                             entry.number.length, entry.number.digits, got, entry.status));
    endtask

    task close_out();
        if (due.size() != 0)
            report($sformatf("%0d status words never arrived", due.size()));
    endtask
endclass

module national_id_check_digit_tb;

    localparam logic [2:0] ADDR_SPARE = 3'd4;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [3:0]  length;
    logic [3:0]  digit_0;
    logic [3:0]  digit_1;
    logic [3:0]  digit_2;
    logic [3:0]  digit_3;
    logic [3:0]  digit_4;
    logic [3:0]  digit_5;
    logic [3:0]  digit_6;
    logic [3:0]  digit_7;
    logic [3:0]  digit_8;
    logic [3:0]  digit_9;
    logic        done;
    logic [3:0]  status;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    id_status_board board = new();

    national_id_check_digit uut (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #2000000;
        $display("national_id_check_digit verification failed");
        $finish;
    end

    // Both monitors see the values from just before the edge.
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            board.note_number({length, digit_9, digit_8, digit_7, digit_6, digit_5,
                               digit_4, digit_3, digit_2, digit_1, digit_0});
        if (rst_n && done)
            board.check_status(status);
    end

    // Builds a well-formed number of the given type; a bad check digit is
    // always a miss, as the offset wraps within four bits.
    function automatic id_number_t make_number(kind_t kind, int unsigned region,
                                               logic [3:0] kind_digit, bit good);
        id_number_t  n;
        int unsigned cd;
        n.length    = ID_LENGTH;
        n.digits[0] = 4'(region / 10);
        n.digits[1] = 4'(region % 10);
        n.digits[2] = kind_digit;
        for (int i = 3; i < 10; i++)
            n.digits[i] = ($urandom_range(9, 0) == 0) ? 4'($urandom_range(15, 0))
                                                      : 4'($urandom_range(9, 0));
        cd = board.check_digit_of(n, kind);
        if (!good)
            cd = cd + $urandom_range(15, 1);
        if (kind == KIND_PUB)
            n.digits[8] = 4'(cd);
        else
            n.digits[9] = 4'(cd);
        return n;
    endfunction

    function automatic id_number_t random_number();
        id_number_t  n;
        kind_t       kind;
        int unsigned pick;
        int unsigned region;
        logic [3:0]  kind_digit;
        pick = $urandom_range(99, 0);
        kind = kind_t'($urandom_range(2, 0));
        case (kind)
            KIND_NAT: kind_digit = 4'($urandom_range(5, 0));
            KIND_PUB: kind_digit = 4'd6;
            default:  kind_digit = 4'd9;
        endcase
        if (board.region_limit == 0)
            region = $urandom_range(9, 1);
        else if ($urandom_range(4, 0) == 0)
            region = board.region_limit;
        else
            region = $urandom_range(board.region_limit, 1);
        n = make_number(kind, region, kind_digit, $urandom_range(9, 0) < 6);
        if (pick >= 94)
        begin
            n.length = ($urandom_range(1, 0) == 0) ? ID_LENGTH : 4'($urandom_range(15, 0));
            for (int i = 0; i < 10; i++)
                n.digits[i] = 4'($urandom_range(15, 0));
        end
        else if (pick >= 88)
        begin
            do
                n.digits[2] = 4'($urandom_range(15, 0));
            while (n.digits[2] <= 4'd6 || n.digits[2] == 4'd9);
        end
        else if (pick >= 80)
        begin
            n.digits[0] = 4'($urandom_range(15, 0));
            n.digits[1] = 4'($urandom_range(15, 0));
            region      = 10 * n.digits[0] + n.digits[1];
            if (region != 0 && region <= board.region_limit)
            begin
                n.digits[0] = 4'd0;
                n.digits[1] = 4'd0;
            end
        end
        else if (pick >= 70)
        begin
            do
                n.length = 4'($urandom_range(15, 0));
            while (n.length == ID_LENGTH);
        end
        return n;
    endfunction

    task automatic drive_fields(input id_number_t n);
        length  <= n.length;
        digit_0 <= n.digits[0];
        digit_1 <= n.digits[1];
        digit_2 <= n.digits[2];
        digit_3 <= n.digits[3];
        digit_4 <= n.digits[4];
        digit_5 <= n.digits[5];
        digit_6 <= n.digits[6];
        digit_7 <= n.digits[7];
        digit_8 <= n.digits[8];
        digit_9 <= n.digits[9];
    endtask

    // Returns at the edge that takes the word.
    task automatic send_number(input id_number_t n);
        bit taken;
        start <= 1'b1;
        drive_fields(n);
        do
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        while (!taken);
    endtask

    task automatic sender_gap(input int unsigned pct);
        if ($urandom_range(99, 0) < pct)
        begin
            start <= 1'b0;
            drive_fields(random_number());
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
    endtask

    task automatic write_register(input logic [2:0] addr, input logic [6:0] value);
        bit ready;
        start <= 1'b0;
        while (board.due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        // Upper data bits are noise; only the low seven bits hold the limit.
        pwdata  <= ($urandom() & 32'hFFFF_FF80) | 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(negedge clk);
            ready = pready;
            @(posedge clk);
        end
        while (!ready);
        if (addr == ADDR_REGION_LIMIT)
            board.region_limit = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial
    begin
        id_number_t  n;
        logic [3:0]  bad_types [4];
        int          limits [9];
        int unsigned idle_pct;
        logic [6:0]  limit;

        bad_types = '{4'd7, 4'd8, 4'd10, 4'd15};
        // A negative entry stands for a random limit.
        limits    = '{99, 1, -1, 127, 24, -1, 0, 99, -1};
        rst_n     = 1'b0;
        start     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = ADDR_REGION_LIMIT;
        pwdata    = 32'd0;
        length    = 4'd0;
        digit_0   = 4'd0;
        digit_1   = 4'd0;
        digit_2   = 4'd0;
        digit_3   = 4'd0;
        digit_4   = 4'd0;
        digit_5   = 4'd0;
        digit_6   = 4'd0;
        digit_7   = 4'd0;
        digit_8   = 4'd0;
        digit_9   = 4'd0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Length errors on an otherwise valid number.
        n = make_number(KIND_NAT, 17, 4'd3, 1'b1);
        n.length = 4'd0;
        send_number(n);
        n.length = 4'd9;
        send_number(n);
        n.length = 4'd15;
        send_number(n);

        // Region edges at the reset limit.
        send_number(make_number(KIND_NAT, 0, 4'd2, 1'b1));
        send_number(make_number(KIND_NAT, 25, 4'd2, 1'b1));
        send_number(make_number(KIND_NAT, 24, 4'd5, 1'b1));
        send_number(make_number(KIND_PRI, 1, 4'd9, 1'b1));

        // Third digit outside the three types.
        n = make_number(KIND_NAT, 10, 4'd0, 1'b1);
        for (int i = 0; i < 4; i++)
        begin
            n.digits[2] = bad_types[i];
            send_number(n);
        end

        send_number(make_number(KIND_NAT, 9, 4'd0, 1'b1));
        send_number(make_number(KIND_NAT, 9, 4'd0, 1'b0));
        send_number(make_number(KIND_PUB, 3, 4'd6, 1'b1));
        send_number(make_number(KIND_PUB, 3, 4'd6, 1'b0));
        send_number(make_number(KIND_PRI, 19, 4'd9, 1'b1));
        send_number(make_number(KIND_PRI, 19, 4'd9, 1'b0));

        // A public sum whose check works out at ten only matches a digit of ten.
        do
            n = make_number(KIND_PUB, 12, 4'd6, 1'b1);
        while (n.digits[8] != 4'd10);
        send_number(n);
        n.digits[8] = 4'd0;
        send_number(n);

        // A digit above nine is weighted too; a term of ten or more loses nine.
        n = make_number(KIND_NAT, 20, 4'd1, 1'b1);
        n.digits[5] = 4'd15;
        n.digits[9] = 4'(board.check_digit_of(n, KIND_NAT));
        send_number(n);

        // A zero limit rejects every region.
        write_register(ADDR_REGION_LIMIT, 7'd0);
        send_number(make_number(KIND_NAT, 1, 4'd0, 1'b1));

        // The widest limit admits regions built from digits above nine.
        write_register(ADDR_REGION_LIMIT, 7'd127);
        send_number(make_number(KIND_PRI, 127, 4'd9, 1'b1));
        send_number(make_number(KIND_PUB, 99, 4'd6, 1'b1));

        for (int s = 0; s < 9; s++)
        begin
            idle_pct = (s < 3) ? 10 : (s < 6) ? 79 : 0;
            limit    = (limits[s] < 0) ? 7'($urandom_range(99, 1)) : 7'(limits[s]);
            write_register(ADDR_REGION_LIMIT, limit);
            // A write to an unmapped address must leave the limit alone.
            if (s == 4)
                write_register(ADDR_SPARE, 7'd3);
            for (int k = 0; k < 170; k++)
            begin
                sender_gap(idle_pct);
                send_number(random_number());
            end
        end

        start <= 1'b0;
        for (int w = 0; w < 100 && board.due.size() != 0; w++)
            @(posedge clk);
        repeat (8) @(posedge clk);
        board.close_out();
        if (board.mismatches == 0)
            $display("national_id_check_digit verification clean");
        else
            $display("national_id_check_digit verification failed");
        $finish;
    end

endmodule
